// ----- rtl/lpmd_pkg.sv -----
package lpmd_pkg;

	// Fixed-point constants
	localparam int CORDIC_STEPS = 24;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic [29:0] RAD_TO_BAM = 30'd683565276;

	// Wide product and sum type
	typedef logic signed [67:0] wide_t;

	localparam wide_t SAT_MAX = 68'sh0_0000_0000_7FFF_FFFF;
	localparam wide_t SAT_MIN = 68'shF_FFFF_FFFF_8000_0000;

	// Multiplier operand selects
	localparam logic [3:0] MUL_W_DT = 4'd0;
	localparam logic [3:0] MUL_MH_C = 4'd1;
	localparam logic [3:0] MUL_ML_C = 4'd2;
	localparam logic [3:0] MUL_V_DT = 4'd3;
	localparam logic [3:0] MUL_D_C  = 4'd4;
	localparam logic [3:0] MUL_D_S  = 4'd5;
	localparam logic [3:0] MUL_C_PX = 4'd6;
	localparam logic [3:0] MUL_S_PY = 4'd7;
	localparam logic [3:0] MUL_S_PX = 4'd8;
	localparam logic [3:0] MUL_C_PY = 4'd9;

	// Datapath operations
	localparam logic [3:0] OP_NONE    = 4'd0;
	localparam logic [3:0] OP_SPLIT   = 4'd1;
	localparam logic [3:0] OP_ALATCH  = 4'd2;
	localparam logic [3:0] OP_HEAD    = 4'd3;
	localparam logic [3:0] OP_DIS     = 4'd4;
	localparam logic [3:0] OP_CSTEP   = 4'd5;
	localparam logic [3:0] OP_POSX    = 4'd6;
	localparam logic [3:0] OP_POSY    = 4'd7;
	localparam logic [3:0] OP_ACC_LD  = 4'd8;
	localparam logic [3:0] OP_ACC_SUB = 4'd9;
	localparam logic [3:0] OP_RX      = 4'd10;
	localparam logic [3:0] OP_ACC_ADD = 4'd11;

	// Controller to datapath commands
	typedef struct packed {
		logic       load;
		logic [3:0] mul_sel;
		logic [3:0] op;
		logic       out_ld;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic crd_done;
	} sts_t;

	// CORDIC arctangent table, binary angle units
	function automatic logic [31:0] atan_bam(input logic [4:0] i);
		logic [31:0] r;
		begin
			unique case (i)
				5'd0:  r = 32'h20000000;
				5'd1:  r = 32'h12E4051E;
				5'd2:  r = 32'h09FB385B;
				5'd3:  r = 32'h051111D4;
				5'd4:  r = 32'h028B0D43;
				5'd5:  r = 32'h0145D7E1;
				5'd6:  r = 32'h00A2F61E;
				5'd7:  r = 32'h00517C55;
				5'd8:  r = 32'h0028BE53;
				5'd9:  r = 32'h00145F2F;
				5'd10: r = 32'h000A2F98;
				5'd11: r = 32'h000517CC;
				5'd12: r = 32'h00028BE6;
				5'd13: r = 32'h000145F3;
				5'd14: r = 32'h0000A2FA;
				5'd15: r = 32'h0000517D;
				5'd16: r = 32'h000028BE;
				5'd17: r = 32'h0000145F;
				5'd18: r = 32'h00000A30;
				5'd19: r = 32'h00000518;
				5'd20: r = 32'h0000028C;
				5'd21: r = 32'h00000146;
				5'd22: r = 32'h000000A3;
				5'd23: r = 32'h00000051;
				default: r = 32'h00000000;
			endcase
			return r;
		end
	endfunction

	// Shift right, rounding half away from zero
	function automatic wide_t rnd_shift(input wide_t v, input int unsigned s);
		logic [67:0] m;
		begin
			m = v[67] ? (68'd0 - v) : v;
			m = (m + (68'd1 << (s - 1))) >> s;
			return v[67] ? $signed(68'd0 - m) : $signed(m);
		end
	endfunction

	// Saturate to 32-bit signed
	function automatic logic signed [31:0] sat32(input wide_t v);
		logic signed [31:0] r;
		begin
			if (v > SAT_MAX)
				r = 32'sh7FFFFFFF;
			else if (v < SAT_MIN)
				r = 32'sh80000000;
			else
				r = v[31:0];
			return r;
		end
	endfunction

endpackage

// ----- rtl/lpmd_ctrl.sv -----
module lpmd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  lpmd_pkg::sts_t    sts,
	output lpmd_pkg::cmd_t    cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MW   = 4'd1;
	localparam logic [3:0] ST_MA   = 4'd2;
	localparam logic [3:0] ST_MB   = 4'd3;
	localparam logic [3:0] ST_HD   = 4'd4;
	localparam logic [3:0] ST_DIS  = 4'd5;
	localparam logic [3:0] ST_CRD  = 4'd6;
	localparam logic [3:0] ST_PX   = 4'd7;
	localparam logic [3:0] ST_PY   = 4'd8;
	localparam logic [3:0] ST_R0   = 4'd9;
	localparam logic [3:0] ST_R1   = 4'd10;
	localparam logic [3:0] ST_R2   = 4'd11;
	localparam logic [3:0] ST_R3   = 4'd12;
	localparam logic [3:0] ST_R4   = 4'd13;
	localparam logic [3:0] ST_OUT  = 4'd14;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_vld_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_vld_q;

	// Sequence one request through the datapath
	always_comb begin
		state_nx    = state_q;
		cmd.load    = 1'b0;
		cmd.mul_sel = lpmd_pkg::MUL_W_DT;
		cmd.op      = lpmd_pkg::OP_NONE;
		cmd.out_ld  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_nx = ST_MW;
				end
			end
			ST_MW: begin
				cmd.mul_sel = lpmd_pkg::MUL_W_DT;
				state_nx    = ST_MA;
			end
			ST_MA: begin
				cmd.mul_sel = lpmd_pkg::MUL_MH_C;
				cmd.op      = lpmd_pkg::OP_SPLIT;
				state_nx    = ST_MB;
			end
			ST_MB: begin
				cmd.mul_sel = lpmd_pkg::MUL_ML_C;
				cmd.op      = lpmd_pkg::OP_ALATCH;
				state_nx    = ST_HD;
			end
			ST_HD: begin
				cmd.mul_sel = lpmd_pkg::MUL_V_DT;
				cmd.op      = lpmd_pkg::OP_HEAD;
				state_nx    = ST_DIS;
			end
			ST_DIS: begin
				cmd.op   = lpmd_pkg::OP_DIS;
				state_nx = ST_CRD;
			end
			ST_CRD: begin
				cmd.op = lpmd_pkg::OP_CSTEP;
				if (sts.crd_done)
					state_nx = ST_PX;
			end
			ST_PX: begin
				cmd.mul_sel = lpmd_pkg::MUL_D_C;
				state_nx    = ST_PY;
			end
			ST_PY: begin
				cmd.mul_sel = lpmd_pkg::MUL_D_S;
				cmd.op      = lpmd_pkg::OP_POSX;
				state_nx    = ST_R0;
			end
			ST_R0: begin
				cmd.mul_sel = lpmd_pkg::MUL_C_PX;
				cmd.op      = lpmd_pkg::OP_POSY;
				state_nx    = ST_R1;
			end
			ST_R1: begin
				cmd.mul_sel = lpmd_pkg::MUL_S_PY;
				cmd.op      = lpmd_pkg::OP_ACC_LD;
				state_nx    = ST_R2;
			end
			ST_R2: begin
				cmd.mul_sel = lpmd_pkg::MUL_S_PX;
				cmd.op      = lpmd_pkg::OP_ACC_SUB;
				state_nx    = ST_R3;
			end
			ST_R3: begin
				cmd.mul_sel = lpmd_pkg::MUL_C_PY;
				cmd.op      = lpmd_pkg::OP_RX;
				state_nx    = ST_R4;
			end
			ST_R4: begin
				cmd.op   = lpmd_pkg::OP_ACC_ADD;
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (!out_vld_q || m_tready) begin
					cmd.out_ld = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// Advance state and hold the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.out_ld)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_vld_q || m_tready))
		else $error("result overwritten while still pending");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_MW))
		else $error("accepted request did not start the sequence");

	a_cordic_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRD && !sts.crd_done) |=> (state_q == ST_CRD))
		else $error("rotation left before its last step");

	a_out_presented: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> (out_vld_q && state_q == ST_IDLE))
		else $error("loaded result not presented");
`endif

endmodule

// ----- rtl/lpmd_dp.sv -----
module lpmd_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  lpmd_pkg::cmd_t      cmd,
	output lpmd_pkg::sts_t      sts,
	input  logic [263:0]        s_tdata,
	input  logic [1:0]          s_tuser,
	output logic [95:0]         m_tdata,
	output logic [1:0]          m_tuser,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [20:0]         cfg_data
);

	localparam logic [4:0] LAST_STEP = 5'(lpmd_pkg::CORDIC_STEPS - 1);

	// Input field views
	logic signed [31:0] in_px, in_py, in_speed, in_trate, in_irate;
	logic [31:0]        in_pz;
	logic signed [21:0] in_dt, in_tgap, in_igap;
	logic               in_imu_av, in_first;

	assign in_px     = s_tdata[31:0];
	assign in_py     = s_tdata[63:32];
	assign in_pz     = s_tdata[95:64];
	assign in_dt     = s_tdata[117:96];
	assign in_tgap   = s_tdata[139:118];
	assign in_speed  = s_tdata[171:140];
	assign in_trate  = s_tdata[203:172];
	assign in_igap   = s_tdata[225:204];
	assign in_irate  = s_tdata[257:226];
	assign in_imu_av = s_tuser[0];
	assign in_first  = s_tuser[1];

	// Registers
	logic [20:0]         gap_limit_q;
	logic                imu_enable_q;
	logic [31:0]         heading_q;
	logic signed [31:0]  pos_x_q, pos_y_q;
	logic signed [31:0]  px_q, py_q, v_q, w_q;
	logic [31:0]         pz_q;
	logic signed [21:0]  dt_q;
	logic                tlate_q, ilate_q;
	lpmd_pkg::wide_t     prod_q;
	logic                neg_q;
	logic [25:0]         ml_q;
	logic [56:0]         a_q;
	logic signed [33:0]  dis_q;
	logic signed [31:0]  cx_q, cy_q, cz_q;
	logic                flip_q;
	logic [4:0]          iter_q;
	logic signed [65:0]  acc_q;
	logic signed [31:0]  rx_q;
	logic signed [31:0]  out_x_q, out_y_q;
	logic [31:0]         out_z_q;
	logic                twist_late_q, imu_late_q;

	// Lateness and rate selection at accept
	logic [21:0] tg_mag, ig_mag;
	logic        tlate, iused, ilate;

	always_comb begin
		tg_mag = in_tgap[21] ? (22'd0 - in_tgap) : in_tgap;
		ig_mag = in_igap[21] ? (22'd0 - in_igap) : in_igap;
		tlate  = tg_mag > {1'b0, gap_limit_q};
		iused  = imu_enable_q & in_imu_av;
		ilate  = iused & (ig_mag > {1'b0, gap_limit_q});
	end

	// Rotation outputs with half-turn correction
	logic signed [31:0] cos_v, sin_v;
	assign cos_v = flip_q ? (32'sd0 - cx_q) : cx_q;
	assign sin_v = flip_q ? (32'sd0 - cy_q) : cy_q;

	// Magnitude of the rate-step product
	logic [67:0] p_mag;
	logic [52:0] pm;
	assign p_mag = prod_q[67] ? (68'd0 - prod_q) : prod_q;
	assign pm    = p_mag[52:0];

	// Select multiplier operands
	logic signed [33:0] mul_a, mul_b;

	always_comb begin
		case (cmd.mul_sel)
			lpmd_pkg::MUL_W_DT: begin mul_a = 34'(w_q);   mul_b = 34'(dt_q); end
			lpmd_pkg::MUL_MH_C: begin
				mul_a = $signed({7'd0, pm[52:26]});
				mul_b = $signed({4'd0, lpmd_pkg::RAD_TO_BAM});
			end
			lpmd_pkg::MUL_ML_C: begin
				mul_a = $signed({8'd0, ml_q});
				mul_b = $signed({4'd0, lpmd_pkg::RAD_TO_BAM});
			end
			lpmd_pkg::MUL_V_DT: begin mul_a = 34'(v_q);   mul_b = 34'(dt_q); end
			lpmd_pkg::MUL_D_C:  begin mul_a = dis_q;      mul_b = 34'(cos_v); end
			lpmd_pkg::MUL_D_S:  begin mul_a = dis_q;      mul_b = 34'(sin_v); end
			lpmd_pkg::MUL_C_PX: begin mul_a = 34'(cos_v); mul_b = 34'(px_q); end
			lpmd_pkg::MUL_S_PY: begin mul_a = 34'(sin_v); mul_b = 34'(py_q); end
			lpmd_pkg::MUL_S_PX: begin mul_a = 34'(sin_v); mul_b = 34'(px_q); end
			lpmd_pkg::MUL_C_PY: begin mul_a = 34'(cos_v); mul_b = 34'(py_q); end
			default:            begin mul_a = 34'sd0;     mul_b = 34'sd0; end
		endcase
	end

	// Heading increment from the split product
	logic [57:0] low_sum;
	logic [31:0] hd_inc;

	always_comb begin
		low_sum = {22'd0, a_q[9:0], 26'd0} + {2'b00, prod_q[55:0]} + (58'd1 << 35);
		hd_inc  = a_q[41:10] + {10'd0, low_sum[57:36]};
	end

	// CORDIC start angle and per-step terms
	logic [31:0]        hd_turn;
	logic               start_flip;
	logic [31:0]        start_ang;
	logic signed [31:0] dx, dy;
	logic [31:0]        atan_v;

	always_comb begin
		hd_turn    = heading_q + 32'h40000000;
		start_flip = hd_turn[31];
		start_ang  = start_flip ? (heading_q + 32'h80000000) : heading_q;
		dx         = cy_q >>> iter_q;
		dy         = cx_q >>> iter_q;
		atan_v     = lpmd_pkg::atan_bam(iter_q);
	end

	assign sts.crd_done = (iter_q == LAST_STEP);

	// Rounded sums for position and output
	lpmd_pkg::wide_t pos_x_sum, pos_y_sum, rx_sum, ry_sum, dis_w;

	always_comb begin
		pos_x_sum = lpmd_pkg::rnd_shift(prod_q, 30) + lpmd_pkg::wide_t'(pos_x_q);
		pos_y_sum = lpmd_pkg::rnd_shift(prod_q, 30) + lpmd_pkg::wide_t'(pos_y_q);
		rx_sum    = lpmd_pkg::rnd_shift(lpmd_pkg::wide_t'(acc_q), 30)
			+ lpmd_pkg::wide_t'(pos_x_q);
		ry_sum    = lpmd_pkg::rnd_shift(lpmd_pkg::wide_t'(acc_q), 30)
			+ lpmd_pkg::wide_t'(pos_y_q);
		dis_w     = lpmd_pkg::rnd_shift(prod_q, 20);
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q  <= 21'd104858;
			imu_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == 1'b0)
				gap_limit_q <= cfg_data;
			else
				imu_enable_q <= cfg_data[0];
		end
	end

	// Scan state: heading and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= 32'd0;
			pos_x_q   <= 32'sd0;
			pos_y_q   <= 32'sd0;
		end else begin
			if (cmd.load && in_first) begin
				heading_q <= 32'd0;
				pos_x_q   <= 32'sd0;
				pos_y_q   <= 32'sd0;
			end
			if (cmd.op == lpmd_pkg::OP_HEAD)
				heading_q <= heading_q + (neg_q ? (32'd0 - hd_inc) : hd_inc);
			if (cmd.op == lpmd_pkg::OP_POSX)
				pos_x_q <= lpmd_pkg::sat32(pos_x_sum);
			if (cmd.op == lpmd_pkg::OP_POSY)
				pos_y_q <= lpmd_pkg::sat32(pos_y_sum);
		end
	end

	// CORDIC step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			iter_q <= 5'd0;
		else if (cmd.op == lpmd_pkg::OP_DIS)
			iter_q <= 5'd0;
		else if (cmd.op == lpmd_pkg::OP_CSTEP && !sts.crd_done)
			iter_q <= iter_q + 5'd1;
	end

	// Datapath payload
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.load) begin
			px_q    <= in_px;
			py_q    <= in_py;
			pz_q    <= in_pz;
			dt_q    <= in_dt;
			v_q     <= tlate ? 32'sd0 : in_speed;
			w_q     <= (iused && !ilate) ? in_irate : (tlate ? 32'sd0 : in_trate);
			tlate_q <= tlate;
			ilate_q <= ilate;
		end
		case (cmd.op)
			lpmd_pkg::OP_SPLIT: begin
				neg_q <= prod_q[67];
				ml_q  <= pm[25:0];
			end
			lpmd_pkg::OP_ALATCH: a_q <= prod_q[56:0];
			lpmd_pkg::OP_DIS: begin
				dis_q  <= dis_w[33:0];
				cx_q   <= lpmd_pkg::CORDIC_GAIN;
				cy_q   <= 32'sd0;
				cz_q   <= $signed(start_ang);
				flip_q <= start_flip;
			end
			lpmd_pkg::OP_CSTEP: begin
				if (!cz_q[31]) begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - $signed(atan_v);
				end else begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + $signed(atan_v);
				end
			end
			lpmd_pkg::OP_ACC_LD:  acc_q <= prod_q[65:0];
			lpmd_pkg::OP_ACC_SUB: acc_q <= acc_q - $signed(prod_q[65:0]);
			lpmd_pkg::OP_RX: begin
				rx_q  <= lpmd_pkg::sat32(rx_sum);
				acc_q <= prod_q[65:0];
			end
			lpmd_pkg::OP_ACC_ADD: acc_q <= acc_q + $signed(prod_q[65:0]);
			default: ;
		endcase
		if (cmd.out_ld) begin
			out_x_q      <= rx_q;
			out_y_q      <= lpmd_pkg::sat32(ry_sum);
			out_z_q      <= pz_q;
			twist_late_q <= tlate_q;
			imu_late_q   <= ilate_q;
		end
	end

	assign m_tdata = {out_z_q, out_y_q, out_x_q};
	assign m_tuser = {imu_late_q, twist_late_q};

endmodule

// ----- rtl/lidar_planar_motion_deskew.sv -----
// Sequence from accept to result valid: rate-step split multiply, 24 CORDIC steps
// on one shared rotator, then 6 multiplies on one 34x34 multiplier.
// One point at a time: the next point is taken once the result is loaded.
// Reset (arst_n low, asynchronous): heading and position clear, gap_limit 104858,
// imu_enable 0, no result pending.
module lidar_planar_motion_deskew (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// point_x, point_y, point_z, time_step, twist_gap, twist_speed,
	// twist_yaw_rate, imu_gap, imu_yaw_rate, zero pad
	input  logic [263:0] s_tdata,
	// imu_available, first_of_scan
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// out_x, out_y, out_z
	output logic [95:0]  m_tdata,
	// twist_late, imu_late
	output logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic         cfg_index,
	input  logic [20:0]  cfg_data
);

	lpmd_pkg::cmd_t cmd;
	lpmd_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	lpmd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpmd_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

// ----- dv/lidar_planar_motion_deskew_tb.sv -----
`timescale 1ns / 100ps

module lidar_planar_motion_deskew_tb;

	// One point request, field by field
	typedef struct {
		logic signed [31:0] px, py, pz;
		logic signed [21:0] dt, tgap;
		logic signed [31:0] speed, trate;
		logic               imu_av;
		logic signed [21:0] igap;
		logic signed [31:0] irate;
		logic               first;
	} point_req_t;

	// One corrected point
	typedef struct {
		logic [31:0] ox, oy, oz;
		logic        tlate, ilate;
	} corrected_t;

	localparam logic CFG_GAP_LIMIT = 1'b0;
	localparam logic CFG_IMU_ENABLE = 1'b1;
	localparam int unsigned TURN_SCALE = 683565276;

	// Deskew predictor and queue of corrected points still to come
	class deskew_board;
		longint unsigned gap_limit = 104858;
		bit imu_enable = 0;
		bit [31:0] heading = 0;
		logic signed [31:0] pos_x = 0, pos_y = 0;
		corrected_t pending[$];
		int errors = 0;
		longint arctan[24] = '{
			'h20000000, 'h12E4051E, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
			'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2F, 'h000A2F98, 'h000517CC,
			'h00028BE6, 'h000145F3, 'h0000A2FA, 'h0000517D, 'h000028BE, 'h0000145F,
			'h00000A30, 'h00000518, 'h0000028C, 'h00000146, 'h000000A3, 'h00000051};

		function longint round_half(longint v, int s);
			bit [63:0] m;
			m = v < 0 ? -v : v;
			m = (m + (64'd1 << (s - 1))) >> s;
			return v < 0 ? -longint'(m) : longint'(m);
		endfunction

		function logic signed [31:0] clamp32(longint v);
			if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
			if (v < -64'sd2147483648) return 32'sh80000000;
			return v[31:0];
		endfunction

		// Rate times step as a binary-angle increment
		function bit [31:0] turn_inc(longint w, longint dt);
			bit neg;
			bit [63:0] m, mh, ml, a, b, low, r;
			neg = (w < 0) != (dt < 0);
			m = (w < 0 ? -w : w) * (dt < 0 ? -dt : dt);
			mh = m >> 26;
			ml = m & ((64'd1 << 26) - 1);
			a = mh * TURN_SCALE;
			b = ml * TURN_SCALE;
			low = ((a & 1023) << 26) + b + (64'd1 << 35);
			r = (a >> 10) + (low >> 36);
			return neg ? 32'd0 - r[31:0] : r[31:0];
		endfunction

		// Rotator over the heading, Q2.30
		function void sin_cos(bit [31:0] ang, output longint c, output longint s);
			bit [31:0] a;
			bit flip;
			longint x, y, z, dx, dy;
			a = ang;
			flip = 0;
			x = 652032874;
			y = 0;
			if (((a + 32'h40000000) & 32'h80000000) != 0) begin
				a += 32'h80000000;
				flip = 1;
			end
			z = longint'($signed(a));
			for (int i = 0; i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= arctan[i];
				end else begin
					x += dx; y -= dy; z += arctan[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void note_request(point_req_t r);
			longint dt, tg, ig, v, w, c, s, dis, rx, ry;
			bit tl, iu, il;
			corrected_t e;
			dt = r.dt;
			tg = r.tgap;
			ig = r.igap;
			tl = (tg < 0 ? -tg : tg) > longint'(gap_limit);
			iu = imu_enable && r.imu_av;
			il = iu && ((ig < 0 ? -ig : ig) > longint'(gap_limit));
			if (r.first) begin
				heading = 0; pos_x = 0; pos_y = 0;
			end
			v = 0;
			w = 0;
			if (!tl) begin
				v = r.speed; w = r.trate;
			end
			if (iu && !il) w = r.irate;
			heading += turn_inc(w, dt);
			sin_cos(heading, c, s);
			dis = round_half(v * dt, 20);
			pos_x = clamp32(longint'(pos_x) + round_half(dis * c, 30));
			pos_y = clamp32(longint'(pos_y) + round_half(dis * s, 30));
			rx = round_half(c * r.px - s * r.py, 30) + pos_x;
			ry = round_half(s * r.px + c * r.py, 30) + pos_y;
			e.ox = clamp32(rx);
			e.oy = clamp32(ry);
			e.oz = r.pz;
			e.tlate = tl;
			e.ilate = il;
			pending.insert(pending.size(), e);
		endfunction

		function void check_result(corrected_t got);
			corrected_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h", $time, got.ox, got.oy);
				errors++;
				return;
			end
			e = pending[0];
			pending.delete(0);
			if (got.ox !== e.ox) begin
				$display("%0t: out_x expected %h actual %h", $time, e.ox, got.ox); errors++;
			end
			if (got.oy !== e.oy) begin
				$display("%0t: out_y expected %h actual %h", $time, e.oy, got.oy); errors++;
			end
			if (got.oz !== e.oz) begin
				$display("%0t: out_z expected %h actual %h", $time, e.oz, got.oz); errors++;
			end
			if (got.tlate !== e.tlate) begin
				$display("%0t: twist_late expected %b actual %b", $time, e.tlate, got.tlate);
				errors++;
			end
			if (got.ilate !== e.ilate) begin
				$display("%0t: imu_late expected %b actual %b", $time, e.ilate, got.ilate);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tready;
	logic [263:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid, m_tready = 0;
	logic [95:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_valid = 0, cfg_ready;
	logic cfg_index = 0;
	logic [20:0] cfg_data = '0;

	deskew_board board = new();
	int send_idle_pct = 0, recv_stall_pct = 0, hold_off = 0;

	lidar_planar_motion_deskew uut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every accepted result
	always @(posedge clk) begin
		corrected_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.ox = m_tdata[31:0];
			got.oy = m_tdata[63:32];
			got.oz = m_tdata[95:64];
			got.tlate = m_tuser[0];
			got.ilate = m_tuser[1];
			board.check_result(got);
		end
	end

	task automatic send_point(point_req_t r);
		s_tvalid <= 1;
		s_tdata <= {6'd0, r.irate, r.igap, r.trate, r.speed, r.tgap, r.dt, r.pz, r.py, r.px};
		s_tuser <= {r.first, r.imu_av};
		do @(posedge clk); while (!s_tready);
		board.note_request(r);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
			@(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (45) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [20:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == CFG_GAP_LIMIT) board.gap_limit = val;
		else board.imu_enable = val[0];
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick32(int unsigned span);
		int unsigned k;
		k = $urandom_range(9);
		if (k == 0) return $urandom();
		if (k == 1)
			return {1'($urandom_range(1)), 31'(0)} | ($urandom_range(1) ? 32'h7FFFFFFF : 0);
		return $signed($urandom_range(2 * span)) - $signed(span);
	endfunction

	// Gap around the limit so both sides of the compare are hit
	function automatic logic [21:0] pick_gap();
		int g;
		if ($urandom_range(7) == 0) return 22'($urandom());
		g = int'(board.gap_limit) + $urandom_range(4) - 2;
		if ($urandom_range(1)) g = $urandom_range(board.gap_limit);
		return 22'($urandom_range(1) ? -g : g);
	endfunction

	function automatic point_req_t rand_point();
		point_req_t r;
		r.px = pick32(100 << 16);
		r.py = pick32(100 << 16);
		r.pz = $urandom();
		r.dt = ($urandom_range(9) == 0) ? 22'($urandom()) : 22'($urandom_range(4000));
		r.tgap = pick_gap();
		r.speed = pick32(30 << 16);
		r.trate = pick32(3 << 16);
		r.imu_av = 1'($urandom_range(1));
		r.igap = pick_gap();
		r.irate = pick32(3 << 16);
		r.first = ($urandom_range(29) == 0);
		return r;
	endfunction

	initial begin
		#20ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		point_req_t r;
		int lims[6];
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, late and IMU cases, first point with a step
		write_reg(CFG_IMU_ENABLE, 1);
		for (int i = 0; i < 14; i++) begin
			r = rand_point();
			r.first = (i == 0 || i == 7);
			case (i)
				0: begin r.dt = 0; r.tgap = 0; r.imu_av = 0; end
				1: begin r.px = 32'h7FFFFFFF; r.py = 32'h7FFFFFFF; r.tgap = 104858;
					r.imu_av = 0; end
				2: begin r.px = 32'h80000000; r.py = 32'h80000000; r.tgap = -104859;
					r.imu_av = 0; end
				3: begin r.speed = 32'h7FFFFFFF; r.dt = 22'h1FFFFF; r.tgap = 0;
					r.imu_av = 0; end
				4: begin r.speed = 32'h80000000; r.dt = 22'h200000; r.tgap = 0;
					r.trate = 32'h80000000; r.imu_av = 0; end
				5: begin r.imu_av = 1; r.igap = 0; r.tgap = 22'h200000; end
				6: begin r.imu_av = 1; r.igap = 104859; r.tgap = 0; end
				7: begin r.dt = 1000; r.tgap = 0; r.imu_av = 1; r.igap = -104858;
					r.irate = 32'h7FFFFFFF; end
				8: begin r.pz = 32'hFFFFFFFF; r.trate = 32'h7FFFFFFF; r.dt = 22'h1FFFFF;
					r.tgap = 0; r.imu_av = 0; end
				default: ;
			endcase
			send_point(r);
		end
		drain();

		// Random phases with varied idling and settings
		lims = '{0, 104858, 1048576, 2097151, 5000, 0};
		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph == 1) ? 85 : (ph == 3 || ph == 5) ? 21 : 0;
			recv_stall_pct = (ph == 2) ? 85 : (ph == 3 || ph == 5) ? 21 : 0;
			write_reg(CFG_GAP_LIMIT, (ph == 5) ? 21'($urandom()) : 21'(lims[ph]));
			write_reg(CFG_IMU_ENABLE, ph % 2 == 0);
			if (ph == 4) begin
				// Hold the receiver off while points keep coming
				hold_off <= 400;
				repeat (30) send_point(rand_point());
			end
			for (int n = 0; n < 285; n++) begin
				if (n == 140) begin
					// Pause until every result is back
					s_tvalid <= 0;
					@(posedge clk);
					while (board.pending.size() != 0) @(posedge clk);
				end
				send_point(rand_point());
			end
			drain();
		end

		if (board.errors == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/lpmd_pkg.sv
rtl/lpmd_ctrl.sv
rtl/lpmd_dp.sv
rtl/lidar_planar_motion_deskew.sv
dv/lidar_planar_motion_deskew_tb.sv
